### sv/motor_command_frame_builder_top_macros.svh
// ----------------------------------------------------------------------------
// motor command frame builder assertion macros
// shared concurrent check forms, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_FRAME_BUILDER_TOP_MACROS_SVH
`define MOTOR_COMMAND_FRAME_BUILDER_TOP_MACROS_SVH

// same-cycle implication, off while reset is held
`define MCFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define MCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mcfb_pkg.sv
// ----------------------------------------------------------------------------
// mcfb_pkg
// types, frame constants and crc helper for the motor command frame builder
// ----------------------------------------------------------------------------
package mcfb_pkg;

    // input request as seen on the push side
    typedef struct packed {
        logic [7:0] left_speed;
        logic [7:0] right_speed;
        logic [2:0] direction;
    } t_cmd_in;

    // one frame byte as seen on the pop side
    typedef struct packed {
        logic [7:0] frame_byte;
        logic [3:0] byte_index;
        logic       last_byte;
    } t_frame_out;

    // classified command held between front and back
    typedef struct packed {
        logic [7:0] left_speed;
        logic [7:0] right_speed;
        logic [7:0] dir_byte;
        logic       known;
    } t_cmd;

    // queue status seen by both neighbors
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef logic [3:0] t_idx;

    // frame constants
    localparam logic [7:0]  FRAME_START   = 8'hFF;
    localparam logic [7:0]  FRAME_COMMAND = 8'h07;
    localparam logic [7:0]  SPEED_TAG     = 8'h01;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    // direction codes and their bytes
    localparam logic [2:0] DIR_FORWARD  = 3'd1;
    localparam logic [2:0] DIR_RIGHT    = 3'd2;
    localparam logic [2:0] DIR_LEFT     = 3'd3;
    localparam logic [2:0] DIR_BACKWARD = 3'd4;
    localparam logic [7:0] BYTE_FORWARD  = 8'b0101_0000;
    localparam logic [7:0] BYTE_RIGHT    = 8'b0100_0000;
    localparam logic [7:0] BYTE_LEFT     = 8'b0001_0000;
    localparam logic [7:0] BYTE_BACKWARD = 8'b0000_0000;

    // byte positions within the frame
    localparam t_idx IDX_START  = 4'd0;
    localparam t_idx IDX_CMD    = 4'd1;
    localparam t_idx IDX_LEFT   = 4'd2;
    localparam t_idx IDX_TAG_L  = 4'd3;
    localparam t_idx IDX_RIGHT  = 4'd4;
    localparam t_idx IDX_TAG_R  = 4'd5;
    localparam t_idx IDX_DIR    = 4'd6;
    localparam t_idx IDX_CRC_LO = 4'd7;
    localparam t_idx IDX_CRC_HI = 4'd8;

    // map a direction code to its command fields
    function automatic t_cmd classify(input t_cmd_in c);
        t_cmd r;
        r.left_speed  = c.left_speed;
        r.right_speed = c.right_speed;
        r.known       = 1'b1;
        unique case (c.direction)
            DIR_FORWARD:  r.dir_byte = BYTE_FORWARD;
            DIR_RIGHT:    r.dir_byte = BYTE_RIGHT;
            DIR_LEFT:     r.dir_byte = BYTE_LEFT;
            DIR_BACKWARD: r.dir_byte = BYTE_BACKWARD;
            default: begin
                r.dir_byte = BYTE_BACKWARD;
                r.known    = 1'b0;
            end
        endcase
        return r;
    endfunction

    // one byte through the reflected crc, bit by bit
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/mcfb_front.sv
// ----------------------------------------------------------------------------
// mcfb_front
// takes requests, decodes the direction and hands them to the queue
// ----------------------------------------------------------------------------
module mcfb_front import mcfb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_cmd_in   i_cmd,
    input  t_q_status i_q_status,
    output logic      o_q_push,
    output t_cmd      o_q_data
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    logic w_accept;

    // stage holds one request until the queue takes it
    assign o_q_push = r_valid && !i_q_status.full;
    assign full     = r_valid && i_q_status.full;
    assign w_accept = push && !full;
    assign o_q_data = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, classified on the way in
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= classify(i_cmd);
        end
    end

endmodule

### sv/mcfb_queue.sv
// ----------------------------------------------------------------------------
// mcfb_queue
// small first-in first-out store of decoded commands between front and back
// ----------------------------------------------------------------------------
module mcfb_queue import mcfb_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_data,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign w_wr           = i_push && !o_status.full;
    assign w_rd           = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/mcfb_back.sv
// ----------------------------------------------------------------------------
// mcfb_back
// walks one command through its frame bytes and runs the crc alongside
// ----------------------------------------------------------------------------
`include "motor_command_frame_builder_top_macros.svh"

module mcfb_back import mcfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_q_head,
    input  t_q_status  i_q_status,
    output logic       o_q_pop,
    output logic       empty,
    input  logic       pop,
    output t_frame_out o_frame
);

    logic        r_busy;
    t_idx        r_idx;
    t_cmd        r_cmd;
    logic [15:0] r_crc;
    logic        r_out_valid;
    t_frame_out  r_out;

    logic        w_advance;
    logic        w_go;
    t_cmd        w_cmd;
    t_idx        w_idx;
    logic [7:0]  w_byte;
    logic        w_last;

    // output register frees up when empty or being drained
    assign w_advance = !r_out_valid || pop;
    assign w_go      = w_advance && (r_busy || !i_q_status.empty);
    assign w_cmd     = r_busy ? r_cmd : i_q_head;
    assign w_idx     = r_busy ? r_idx : IDX_START;
    assign o_q_pop   = w_go && !r_busy;
    assign w_last    = w_cmd.known ? (w_idx == IDX_CRC_HI) : (w_idx == IDX_TAG_R);
    assign empty     = !r_out_valid;
    assign o_frame   = r_out;

    // byte select
    always_comb begin
        unique case (w_idx)
            IDX_START:  w_byte = FRAME_START;
            IDX_CMD:    w_byte = FRAME_COMMAND;
            IDX_LEFT:   w_byte = w_cmd.left_speed;
            IDX_TAG_L:  w_byte = SPEED_TAG;
            IDX_RIGHT:  w_byte = w_cmd.right_speed;
            IDX_TAG_R:  w_byte = SPEED_TAG;
            IDX_DIR:    w_byte = w_cmd.dir_byte;
            IDX_CRC_LO: w_byte = r_crc[7:0];
            IDX_CRC_HI: w_byte = r_crc[15:8];
            default:    w_byte = FRAME_START;
        endcase
    end

    // frame sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= IDX_START;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_busy      <= !w_last;
                r_idx       <= w_idx + 4'd1;
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command hold, crc and output payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_head;
        end
        if (w_go) begin
            r_out.frame_byte <= w_byte;
            r_out.byte_index <= w_idx;
            r_out.last_byte  <= w_last;
            if (w_idx == IDX_START) begin
                r_crc <= CRC_INIT;
            end else if (w_idx <= IDX_DIR) begin
                r_crc <= crc_feed(r_crc, w_byte);
            end
        end
    end

    // checks
    `MCFB_ASSERT_NOW(a_last_pos, i_clk, i_rst_n, r_out_valid && r_out.last_byte, r_out.byte_index == IDX_TAG_R || r_out.byte_index == IDX_CRC_HI, "last byte at wrong index")
    `MCFB_ASSERT_NOW(a_start_has_cmd, i_clk, i_rst_n, w_go && !r_busy, !i_q_status.empty, "frame start without command")
    `MCFB_ASSERT_NEXT(a_busy_after_mid, i_clk, i_rst_n, w_go && !w_last, r_busy, "frame dropped before last byte")

endmodule

### sv/motor_command_frame_builder_top.sv
// ----------------------------------------------------------------------------
// motor_command_frame_builder_top: drive command to byte frame with crc-16
// path: a taken request passes the input stage, the queue and the output register
// throughput: one byte per cycle unless pop stalls; 9 bytes a frame (6 if short)
// reset: synchronous active low, empties the input stage, queue and output
// ----------------------------------------------------------------------------
module motor_command_frame_builder_top import mcfb_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_cmd_in    i_cmd,
    output logic       empty,
    input  logic       pop,
    output t_frame_out o_frame
);

    logic      w_q_push;
    t_cmd      w_q_data;
    logic      w_q_pop;
    t_cmd      w_q_head;
    t_q_status w_q_status;

    // request intake and direction decode
    mcfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cmd      (i_cmd),
        .i_q_status (w_q_status),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_data)
    );

    // decoupling queue
    mcfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_data   (w_q_data),
        .i_pop    (w_q_pop),
        .o_head   (w_q_head),
        .o_status (w_q_status)
    );

    // frame byte sequencer
    mcfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_head   (w_q_head),
        .i_q_status (w_q_status),
        .o_q_pop    (w_q_pop),
        .empty      (empty),
        .pop        (pop),
        .o_frame    (o_frame)
    );

endmodule
